// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the dispatch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/efsd_pkg.sv -----
// Package: constants, register codes and config struct of the dispatch block.
package efsd_pkg;

	localparam int SERVERS   = 4;
	localparam int TIME_REGS = 4;
	localparam int ACTIVE    = (SERVERS < TIME_REGS) ? SERVERS : TIME_REGS;
	localparam int TAG_W     = 16;
	localparam int IDX_W     = 2;
	localparam int TIME_W    = 16;
	localparam int CNT_W     = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [2:0] {
		REG_SERVER_COUNT   = 3'd0,
		REG_SERVICE_TIME_0 = 3'd1,
		REG_SERVICE_TIME_1 = 3'd2,
		REG_SERVICE_TIME_2 = 3'd3,
		REG_SERVICE_TIME_3 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SERVERS-1:0]  enable;
		time_t [SERVERS-1:0] service_time;
	} efsd_cfg_t;

endpackage

// ----- rtl/core/efsd_ifs.sv -----
// Handshake interfaces for the job and result channels.
interface efsd_job_if import efsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TAG_W-1:0] job_tag;

	modport source (output valid, output job_tag, input ready);
	modport sink (input valid, input job_tag, output ready);
endinterface

interface efsd_result_if import efsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TAG_W-1:0] job_tag_out;
	logic [IDX_W-1:0] server_index;

	modport source (output valid, output job_tag_out, output server_index, input ready);
	modport sink (input valid, input job_tag_out, input server_index, output ready);
endinterface

// ----- rtl/core/earliest_free_server_dispatch.sv -----
// Earliest-free-server dispatch: takes one job per cycle unless stalled, reports its server.
// Each job on the jobs channel is routed to the enabled server (the lowest server_count
// servers, zero read as one, clamped to four) whose next-free time is smallest, ties going to
// the lowest index; the result carries the job tag and that server index. The chosen server
// is then charged its service time and all enabled free times are rebased to a zero minimum,
// while disabled servers keep their free time until enabled again. Throughput is one job per
// clock while results are taken; a job passes the input register, then the result register.
// The rate is set by the combinational free-time update (argmin over four 16-bit times, one
// add, a second minimum and a subtract) between the input register and the state.
// The result register lets the next job enter while a result waits to be taken. Reset clears
// all free times at once; there is no clearing pass. Configuration goes through the APB port;
// the user must write it only while no job is in flight; the block does not enforce this.
module earliest_free_server_dispatch import efsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	efsd_job_if.sink          jobs,
	efsd_result_if.source     dispatches,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	efsd_cfg_t        cfg;
	logic             valid_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             out_valid_q;
	logic [TAG_W-1:0] out_tag_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             advance;
	logic [IDX_W-1:0] best;

	efsd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the held job into the result register whenever that register is free
	// or being emptied this cycle; the free-time state steps at the same edge
	assign advance    = valid_s1 && (!out_valid_q || dispatches.ready);
	assign jobs.ready = !valid_s1 || advance;

	efsd_select u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.best   (best)
	);

	// input register: load a new job whenever the stage is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (jobs.ready) begin
			valid_s1 <= jobs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (jobs.valid && jobs.ready) tag_s1 <= jobs.job_tag;
	end

	// result register: hold until the consumer takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (dispatches.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_tag_q <= tag_s1;
			out_idx_q <= best;
		end
	end

	assign dispatches.valid        = out_valid_q;
	assign dispatches.job_tag_out  = out_tag_q;
	assign dispatches.server_index = out_idx_q;

endmodule

// ----- rtl/core/efsd_cfg_regs.sv -----
// APB configuration registers: server count and per-server service times.
module efsd_cfg_regs import efsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output efsd_cfg_t         cfg
);

	logic [CNT_W-1:0] count_q;
	time_t            st_q [TIME_REGS];
	logic             wr_en;
	reg_idx_t         reg_idx;
	logic [CNT_W-1:0] n_active;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(4);
			for (int i = 0; i < TIME_REGS; i++) st_q[i] <= TIME_W'(1);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SERVER_COUNT:   count_q  <= pwdata[CNT_W-1:0];
				REG_SERVICE_TIME_0: st_q[0] <= pwdata[TIME_W-1:0];
				REG_SERVICE_TIME_1: st_q[1] <= pwdata[TIME_W-1:0];
				REG_SERVICE_TIME_2: st_q[2] <= pwdata[TIME_W-1:0];
				REG_SERVICE_TIME_3: st_q[3] <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SERVER_COUNT:   prdata = DATA_W'(count_q);
			REG_SERVICE_TIME_0: prdata = DATA_W'(st_q[0]);
			REG_SERVICE_TIME_1: prdata = DATA_W'(st_q[1]);
			REG_SERVICE_TIME_2: prdata = DATA_W'(st_q[2]);
			REG_SERVICE_TIME_3: prdata = DATA_W'(st_q[3]);
			default:            prdata = '0;
		endcase
	end

	// zero counts as one server, anything above the usable servers is clamped
	always_comb begin
		if (count_q == '0) n_active = CNT_W'(1);
		else if (count_q > CNT_W'(ACTIVE)) n_active = CNT_W'(ACTIVE);
		else n_active = count_q;
		for (int i = 0; i < SERVERS; i++) begin
			cfg.enable[i]       = CNT_W'(i) < n_active;
			cfg.service_time[i] = (i < TIME_REGS) ? st_q[i] : '0;
		end
	end

endmodule

// ----- rtl/core/efsd_select.sv -----
// Free-time state: pick the earliest free server, charge it, rebase the rest.
module efsd_select import efsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  efsd_cfg_t        cfg,
	input  logic             step,
	output logic [IDX_W-1:0] best
);
`include "assert_macros.svh"

	time_t [SERVERS-1:0] ft_q;
	time_t [SERVERS-1:0] ft_d;
	logic [TIME_W:0]     upd [SERVERS];
	logic [TIME_W:0]     sum;
	logic [TIME_W:0]     lo;
	logic                any_zero;

	always_comb begin
		best = '0;
		for (int i = 1; i < SERVERS; i++) begin
			if (cfg.enable[i] && (ft_q[i] < ft_q[best])) best = IDX_W'(i);
		end
		sum = {1'b0, ft_q[best]} + {1'b0, cfg.service_time[best]};
		for (int i = 0; i < SERVERS; i++) begin
			upd[i] = (IDX_W'(i) == best) ? sum : {1'b0, ft_q[i]};
		end
		// new minimum over enabled servers; server zero is always enabled
		lo = upd[0];
		for (int i = 1; i < SERVERS; i++) begin
			if (cfg.enable[i] && (upd[i] < lo)) lo = upd[i];
		end
		// disabled servers hold their free time
		for (int i = 0; i < SERVERS; i++) begin
			ft_d[i] = cfg.enable[i] ? TIME_W'(upd[i] - lo) : ft_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q <= '0;
		end else if (step) begin
			ft_q <= ft_d;
		end
	end

	always_comb begin
		any_zero = 1'b0;
		for (int i = 0; i < SERVERS; i++) begin
			if (cfg.enable[i] && (ft_q[i] == '0)) any_zero = 1'b1;
		end
	end

	`ASSERT_IMPL(a_best_enabled, clk, arst_n, step, cfg.enable[best], "chose a disabled server")
	`ASSERT_NEXT(a_rebased, clk, arst_n, step, any_zero, "no enabled server at zero after step")
	`ASSERT_NEXT(a_hold, clk, arst_n, !step, $stable(ft_q), "free times moved without a job")

endmodule
